### hw/rtl/cmos_pkg.sv
// shared types for the capture move order sorter: record layout, control word
// layout, step and condition codes, and the microcode table
// no dependencies
package cmos_pkg;

   localparam int MAX_RECORDS_DEF = 64;

   typedef struct packed {
      logic [2:0] attacker;
      logic [2:0] victim;
      logic [6:0] from_sq;
      logic [6:0] to_sq;
      logic [2:0] kind;
   } rec_type;

   typedef enum logic [3:0] {
      STEP_LOAD,
      STEP_INIT,
      STEP_RD_N,
      STEP_LD_CUR,
      STEP_CHK_I,
      STEP_CMP,
      STEP_WR_N,
      STEP_E_INIT,
      STEP_E_RD,
      STEP_E_OUT,
      STEP_E_NEXT,
      STEP_CLEAR
   } step_type;

   typedef enum logic [2:0] {
      COND_ALWAYS,
      COND_LAST_IN,
      COND_I_END,
      COND_N_END,
      COND_OUT_FREE
   } cond_type;

   typedef struct packed {
      logic     accept;
      logic     clr_n;
      logic     rd_i;
      logic     ld_cur;
      logic     cmp;
      logic     wr_n;
      logic     clr_i;
      logic     emit;
      logic     clr_seg;
      cond_type cond;
      step_type tgt_t;
      step_type tgt_f;
   } ctrl_type;

   typedef struct packed {
      logic last_in;
      logic i_end;
      logic n_end;
      logic out_free;
   } flags_type;

   localparam ctrl_type CTRL_NOP = '{
      accept: 1'b0, clr_n: 1'b0, rd_i: 1'b0, ld_cur: 1'b0, cmp: 1'b0,
      wr_n: 1'b0, clr_i: 1'b0, emit: 1'b0, clr_seg: 1'b0,
      cond: COND_ALWAYS, tgt_t: STEP_LOAD, tgt_f: STEP_LOAD};

   function automatic ctrl_type ucode_rom(step_type step);
      ctrl_type w;
      w = CTRL_NOP;
      unique case (step)
         STEP_LOAD: begin
            w.accept = 1'b1;
            w.cond   = COND_LAST_IN;
            w.tgt_t  = STEP_INIT;
            w.tgt_f  = STEP_LOAD;
         end
         STEP_INIT: begin
            w.clr_n = 1'b1;
            w.tgt_t = STEP_RD_N;
         end
         STEP_RD_N: begin
            w.tgt_t = STEP_LD_CUR;
         end
         STEP_LD_CUR: begin
            w.ld_cur = 1'b1;
            w.tgt_t  = STEP_CHK_I;
         end
         STEP_CHK_I: begin
            w.rd_i  = 1'b1;
            w.cond  = COND_I_END;
            w.tgt_t = STEP_WR_N;
            w.tgt_f = STEP_CMP;
         end
         STEP_CMP: begin
            w.cmp   = 1'b1;
            w.tgt_t = STEP_CHK_I;
         end
         STEP_WR_N: begin
            w.wr_n  = 1'b1;
            w.cond  = COND_N_END;
            w.tgt_t = STEP_E_INIT;
            w.tgt_f = STEP_RD_N;
         end
         STEP_E_INIT: begin
            w.clr_i = 1'b1;
            w.tgt_t = STEP_E_RD;
         end
         STEP_E_RD: begin
            w.rd_i  = 1'b1;
            w.tgt_t = STEP_E_OUT;
         end
         STEP_E_OUT: begin
            w.rd_i  = 1'b1;
            w.emit  = 1'b1;
            w.cond  = COND_OUT_FREE;
            w.tgt_t = STEP_E_NEXT;
            w.tgt_f = STEP_E_OUT;
         end
         STEP_E_NEXT: begin
            w.rd_i  = 1'b1;
            w.cond  = COND_I_END;
            w.tgt_t = STEP_CLEAR;
            w.tgt_f = STEP_E_OUT;
         end
         STEP_CLEAR: begin
            w.clr_seg = 1'b1;
            w.tgt_t   = STEP_LOAD;
         end
         default: w = CTRL_NOP;
      endcase
      return w;
   endfunction

endpackage

### hw/rtl/capture_move_order_sorter_core.sv
// top level of the capture move order sorter: record store, sort datapath
// and output register; depends on cmos_pkg and cmos_seq
//
// usage: capture records arrive on the req_ channel, one item per cycle,
// until an item with req_is_last set. a record that arrives while
// MAX_RECORDS are held is dropped and rsp_overflow is set on the results.
// after the last item req_stall goes high while the segment is sorted in
// descending order of victim minus attacker, then the sorted records leave
// on the rsp_ channel with rsp_out_last on the final one.
// the sort keeps record n in a register and streams the later entries
// through the single read port of the store; emission waits while the
// receiver stalls the output register.
// the output register lets the next segment start loading while the last
// result still waits; a stalled result holds its payload until taken.
// reset (synchronous) empties the segment and drops any pending result;
// the store itself is not cleared, only written entries are ever used.
module capture_move_order_sorter_core #(
   parameter int MAX_RECORDS = cmos_pkg::MAX_RECORDS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_attacker_piece,
   input  logic [2:0] req_victim_piece,
   input  logic [6:0] req_from_square,
   input  logic [6:0] req_to_square,
   input  logic [2:0] req_move_kind,
   input  logic       req_is_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_out_attacker,
   output logic [2:0] rsp_out_victim,
   output logic [6:0] rsp_out_from,
   output logic [6:0] rsp_out_to,
   output logic [2:0] rsp_out_kind,
   output logic       rsp_out_last,
   output logic       rsp_overflow
);
   import cmos_pkg::*;

   localparam int AW = $clog2(MAX_RECORDS);
   localparam int CW = $clog2(MAX_RECORDS + 1);

   ctrl_type  ctrl;
   flags_type flags;

   rec_type mem_ff [MAX_RECORDS];
   rec_type rdata_ff;
   rec_type cur_ff, cur_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] i_ff, i_in;
   logic [CW-1:0] n_next, i_next;
   logic          dropped_ff, dropped_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rec_type       rsp_rec_ff, rsp_rec_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_ovf_ff, rsp_ovf_in;

   logic          in_fire, full, store_in, swap, emit_fire, out_free;
   logic [AW-1:0] raddr, waddr;
   logic          we;
   rec_type       wdata, in_rec;
   logic [3:0]    lhs, rhs;

   cmos_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctrl  (ctrl)
   );

   assign req_stall = !ctrl.accept;
   assign in_fire   = req_valid && ctrl.accept;
   assign full      = (count_ff == CW'(MAX_RECORDS));
   assign store_in  = in_fire && !full;
   assign n_next    = n_ff + 1'b1;
   assign i_next    = i_ff + 1'b1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_fire = ctrl.emit && out_free;

   assign in_rec = '{attacker: req_attacker_piece, victim: req_victim_piece,
                     from_sq: req_from_square, to_sq: req_to_square,
                     kind: req_move_kind};

   // key(cur) < key(rd) rewritten as a compare of two unsigned sums
   assign lhs  = {1'b0, cur_ff.victim} + {1'b0, rdata_ff.attacker};
   assign rhs  = {1'b0, rdata_ff.victim} + {1'b0, cur_ff.attacker};
   assign swap = ctrl.cmp && (lhs < rhs);

   assign flags = '{last_in: in_fire && req_is_last, i_end: (i_ff == count_ff),
                    n_end: (n_next == count_ff), out_free: out_free};

   assign raddr = ctrl.rd_i ? i_ff[AW-1:0] : n_ff[AW-1:0];

   always_comb begin
      priority if (store_in) begin
         we    = 1'b1;
         waddr = count_ff[AW-1:0];
         wdata = in_rec;
      end else if (swap) begin
         we    = 1'b1;
         waddr = i_ff[AW-1:0];
         wdata = cur_ff;
      end else if (ctrl.wr_n) begin
         we    = 1'b1;
         waddr = n_ff[AW-1:0];
         wdata = cur_ff;
      end else begin
         we    = 1'b0;
         waddr = n_ff[AW-1:0];
         wdata = cur_ff;
      end
   end

   always_comb begin
      count_in   = count_ff;
      dropped_in = dropped_ff;
      if (store_in) count_in = count_ff + 1'b1;
      if (in_fire && full) dropped_in = 1'b1;
      if (ctrl.clr_seg) begin
         count_in   = '0;
         dropped_in = 1'b0;
      end

      n_in = n_ff;
      if (ctrl.clr_n) n_in = '0;
      else if (ctrl.wr_n) n_in = n_next;

      i_in = i_ff;
      if (ctrl.ld_cur) i_in = n_next;
      else if (ctrl.cmp || emit_fire) i_in = i_next;
      else if (ctrl.clr_i) i_in = '0;

      // the larger key travels on with the running record
      cur_in = cur_ff;
      if (ctrl.ld_cur || swap) cur_in = rdata_ff;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_rec_in   = rsp_rec_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      if (emit_fire) begin
         rsp_valid_in = 1'b1;
         rsp_rec_in   = rdata_ff;
         rsp_last_in  = (i_next == count_ff);
         rsp_ovf_in   = dropped_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      rsp_rec_ff  <= rsp_rec_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      if (reset) begin
         count_ff     <= '0;
         dropped_ff   <= 1'b0;
         n_ff         <= '0;
         i_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         dropped_ff   <= dropped_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_attacker = rsp_rec_ff.attacker;
   assign rsp_out_victim   = rsp_rec_ff.victim;
   assign rsp_out_from     = rsp_rec_ff.from_sq;
   assign rsp_out_to       = rsp_rec_ff.to_sq;
   assign rsp_out_kind     = rsp_rec_ff.kind;
   assign rsp_out_last     = rsp_last_ff;
   assign rsp_overflow     = rsp_ovf_ff;

endmodule

### hw/rtl/cmos_seq.sv
// microcode sequencer: step counter, control table lookup and jumps
// depends on cmos_pkg
module cmos_seq (
   input  logic                clock,
   input  logic                reset,
   input  cmos_pkg::flags_type flags,
   output cmos_pkg::ctrl_type  ctrl
);
   import cmos_pkg::*;

   step_type step_ff;
   step_type step_in;
   logic     taken;

   assign ctrl = ucode_rom(step_ff);

   always_comb begin
      unique case (ctrl.cond)
         COND_ALWAYS:   taken = 1'b1;
         COND_LAST_IN:  taken = flags.last_in;
         COND_I_END:    taken = flags.i_end;
         COND_N_END:    taken = flags.n_end;
         COND_OUT_FREE: taken = flags.out_free;
         default:       taken = 1'b1;
      endcase
      step_in = taken ? ctrl.tgt_t : ctrl.tgt_f;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_LOAD;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule

### sim/tb_capture_move_order_sorter_core.sv
// self-checking testbench for capture_move_order_sorter_core: directed and random
// capture segments, descending victim-minus-attacker ordering checked per result
// depends on cmos_pkg and the core rtl
module tb_capture_move_order_sorter_core;
   import cmos_pkg::*;

   localparam int MAX_RECS   = MAX_RECORDS_DEF;
   localparam int IDLE_LIMIT = 20000;
   localparam int TAIL_WAIT  = 300;

   typedef struct {
      rec_type rec;
      bit      last;
      int      pre_gap;
      bit      drain;
   } feed_item_type;

   typedef struct {
      rec_type rec;
      bit      last;
      bit      ovf;
   } sorted_move_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_attacker_piece = '0;
   logic [2:0] req_victim_piece = '0;
   logic [6:0] req_from_square = '0;
   logic [6:0] req_to_square = '0;
   logic [2:0] req_move_kind = '0;
   logic       req_is_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_out_attacker;
   logic [2:0] rsp_out_victim;
   logic [6:0] rsp_out_from;
   logic [6:0] rsp_out_to;
   logic [2:0] rsp_out_kind;
   logic       rsp_out_last;
   logic       rsp_overflow;

   feed_item_type   move_feed_q[$];
   sorted_move_type sorted_moves_q[$];
   rec_type         seg_recs[$];
   bit              seg_dropped = 1'b0;

   bit req_taken = 1'b0;
   int gap_count = 0;
   int stall_left = 0;
   int cycle_no = 0;
   int idle_cycles = 0;
   bit calm;
   int errors = 0;
   int results_checked = 0;
   int segments_seen = 0;
   int ovf_segments = 0;

   capture_move_order_sorter_core dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_attacker_piece (req_attacker_piece),
      .req_victim_piece   (req_victim_piece),
      .req_from_square    (req_from_square),
      .req_to_square      (req_to_square),
      .req_move_kind      (req_move_kind),
      .req_is_last        (req_is_last),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_out_attacker   (rsp_out_attacker),
      .rsp_out_victim     (rsp_out_victim),
      .rsp_out_from       (rsp_out_from),
      .rsp_out_to         (rsp_out_to),
      .rsp_out_kind       (rsp_out_kind),
      .rsp_out_last       (rsp_out_last),
      .rsp_overflow       (rsp_overflow)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // windows in which no new idling starts on either side
   assign calm = (cycle_no % 2500) < 500;

   // mostly short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      else if (r < 90) return $urandom_range(1, 3);
      else if (r < 98) return $urandom_range(4, 10);
      else return $urandom_range(20, 60);
   endfunction

   function automatic int move_gain(rec_type r);
      return int'(r.victim) - int'(r.attacker);
   endfunction

   function automatic rec_type make_rec(int att, int vic, int fr, int to, int kd);
      rec_type r;
      r.attacker = 3'(att);
      r.victim   = 3'(vic);
      r.from_sq  = 7'(fr);
      r.to_sq    = 7'(to);
      r.kind     = 3'(kd);
      return r;
   endfunction

   task automatic queue_move(rec_type r, bit last, bit drain);
      feed_item_type it;
      it.rec     = r;
      it.last    = last;
      it.pre_gap = pick_gap();
      it.drain   = drain;
      move_feed_q.push_back(it);
   endtask

   task automatic queue_segment(int len, bit drain);
      for (int k = 0; k < len; k++) begin
         queue_move(make_rec($urandom_range(0, 7), $urandom_range(0, 7),
                             $urandom_range(0, 127), $urandom_range(0, 127),
                             $urandom_range(0, 7)),
                    k == len - 1, drain && k == 0);
      end
   endtask

   // exchange sort, same compare/swap order as the block so ties land alike
   task automatic order_segment();
      rec_type         tmp;
      sorted_move_type e;
      for (int n = 0; n < seg_recs.size(); n++) begin
         for (int i = n + 1; i < seg_recs.size(); i++) begin
            if (move_gain(seg_recs[n]) < move_gain(seg_recs[i])) begin
               tmp         = seg_recs[n];
               seg_recs[n] = seg_recs[i];
               seg_recs[i] = tmp;
            end
         end
      end
      for (int k = 0; k < seg_recs.size(); k++) begin
         e.rec  = seg_recs[k];
         e.last = (k == seg_recs.size() - 1);
         e.ovf  = seg_dropped;
         sorted_moves_q.push_back(e);
      end
      segments_seen++;
      if (seg_dropped) ovf_segments++;
      seg_recs.delete();
      seg_dropped = 1'b0;
   endtask

   task automatic capture_record(rec_type r, bit last);
      if (seg_recs.size() < MAX_RECS) seg_recs.push_back(r);
      else seg_dropped = 1'b1;
      if (last) order_segment();
   endtask

   task automatic check_field(string what, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_v, act_v);
         errors++;
      end
   endtask

   // input driver, changes at the falling edge
   always @(negedge clock) begin : feed_drive
      feed_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         gap_count <= 0;
      end else if (!req_valid || req_taken) begin
         if (move_feed_q.size() == 0) begin
            req_valid <= 1'b0;
         end else begin
            nxt = move_feed_q[0];
            if ((!calm && gap_count < nxt.pre_gap) ||
                (nxt.drain && sorted_moves_q.size() != 0)) begin
               req_valid <= 1'b0;
               gap_count <= gap_count + 1;
            end else begin
               void'(move_feed_q.pop_front());
               req_attacker_piece <= nxt.rec.attacker;
               req_victim_piece   <= nxt.rec.victim;
               req_from_square    <= nxt.rec.from_sq;
               req_to_square      <= nxt.rec.to_sq;
               req_move_kind      <= nxt.rec.kind;
               req_is_last        <= nxt.last;
               req_valid          <= 1'b1;
               gap_count          <= 0;
            end
         end
      end
   end

   // result-side back pressure
   always @(negedge clock) begin : stall_drive
      logic s;
      s = 1'b0;
      if (reset) begin
         stall_left = 0;
      end else if (stall_left > 0) begin
         s = 1'b1;
         stall_left = stall_left - 1;
      end else if (!calm && $urandom_range(0, 99) >= 70) begin
         s = 1'b1;
         stall_left = pick_gap();
      end
      rsp_stall <= s;
   end

   // monitor: predictor update on accepted items, check on accepted results
   always @(posedge clock) begin : watch_ports
      sorted_move_type e;
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            capture_record(make_rec(req_attacker_piece, req_victim_piece, req_from_square,
                                    req_to_square, req_move_kind), req_is_last);
         end
         if (rsp_valid && !rsp_stall) begin
            if (sorted_moves_q.size() == 0) begin
               $display("%0t: result with nothing expected, actual from %0d to %0d",
                        $time, rsp_out_from, rsp_out_to);
               errors++;
            end else begin
               e = sorted_moves_q.pop_front();
               check_field("attacker", e.rec.attacker, rsp_out_attacker);
               check_field("victim", e.rec.victim, rsp_out_victim);
               check_field("from", e.rec.from_sq, rsp_out_from);
               check_field("to", e.rec.to_sq, rsp_out_to);
               check_field("kind", e.rec.kind, rsp_out_kind);
               check_field("last", e.last, rsp_out_last);
               check_field("overflow", e.ovf, rsp_overflow);
               results_checked++;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         cycle_no <= cycle_no + 1;
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
            $display("capture_move_order_sorter_core regression: fail");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin : run_seq
      int total;
      int seg_no;
      int len;
      int r;

      // single records at the field extremes, out-of-range piece codes included
      queue_move(make_rec(0, 0, 0, 0, 0), 1'b1, 1'b0);
      queue_move(make_rec(7, 7, 127, 127, 7), 1'b1, 1'b0);
      // keys rising from -7 to +7, full reversal needed
      queue_move(make_rec(7, 0, 1, 2, 1), 1'b0, 1'b0);
      queue_move(make_rec(6, 1, 3, 4, 2), 1'b0, 1'b0);
      queue_move(make_rec(4, 4, 5, 6, 3), 1'b0, 1'b0);
      queue_move(make_rec(1, 6, 7, 8, 4), 1'b0, 1'b0);
      queue_move(make_rec(0, 7, 9, 10, 5), 1'b1, 1'b0);
      // repeated keys, tie placement follows the swap order
      queue_move(make_rec(1, 2, 10, 20, 1), 1'b0, 1'b0);
      queue_move(make_rec(2, 3, 11, 21, 2), 1'b0, 1'b0);
      queue_move(make_rec(3, 3, 12, 22, 3), 1'b0, 1'b0);
      queue_move(make_rec(4, 5, 13, 23, 4), 1'b0, 1'b0);
      queue_move(make_rec(5, 5, 14, 24, 5), 1'b1, 1'b0);
      // already in order
      queue_move(make_rec(0, 7, 100, 101, 6), 1'b0, 1'b1);
      queue_move(make_rec(3, 3, 102, 103, 7), 1'b0, 1'b0);
      queue_move(make_rec(7, 0, 104, 105, 0), 1'b1, 1'b0);

      // store overflows, the last-marked item itself is dropped
      queue_segment(MAX_RECS + 1, 1'b1);
      total  = MAX_RECS + 1;
      seg_no = 0;
      while (total < 360) begin
         r = $urandom_range(0, 99);
         if (seg_no == 4) len = MAX_RECS;
         else if (r < 85) len = $urandom_range(1, 8);
         else if (r < 95) len = $urandom_range(9, 20);
         else len = $urandom_range(MAX_RECS - 4, MAX_RECS + 6);
         queue_segment(len, $urandom_range(0, 9) == 0);
         total += len;
         seg_no++;
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (move_feed_q.size() != 0 || req_valid) @(posedge clock);
      while (sorted_moves_q.size() != 0) @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      if (sorted_moves_q.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, sorted_moves_q.size());
         errors++;
      end
      $display("covered %0d segments, %0d of them with dropped records", segments_seen,
               ovf_segments);
      $display("%0d sorted results compared, %0d mismatches", results_checked, errors);
      if (errors == 0) begin
         $display("capture_move_order_sorter_core regression: pass");
      end else begin
         $display("capture_move_order_sorter_core regression: fail");
      end
      $finish;
   end

endmodule
